/* hw/rtl/dda_pkg.sv */
// shared types and constants for the dda line rasterizer
// no dependencies; used by dda_ctrl, dda_dp and dda_line_rasterizer_unit
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  // coordinate width, fixed by the beat fields
  localparam int unsigned COORD_BITS = 10;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // input beat
  typedef struct packed {
    logic                  operation;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_beat_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // start beat accepted: latch line, prime x division
    logic div_step;  // one restoring division step
    logic commit_x;  // store x increment, prime y division
    logic commit_y;  // store y increment, arm pixel count
    logic tick;      // tick beat accepted with pixels left: emit pixel
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic step_zero;     // latched line has zero length
    logic div_last;      // current division step is the final one
    logic pixels_active; // pixels left on the current line
    logic out_blocked;   // output register full and stalled
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/dda_ctrl.sv */
// controller state machine for the dda line rasterizer
// depends on dda_pkg
`timescale 1ns / 1ps
`default_nettype none

module dda_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_stall,
  input  wire dda_pkg::sts_t sts,
  output dda_pkg::cmd_t      cmd,
  output dda_pkg::state_t    state
);

  dda_pkg::state_t state_r;
  dda_pkg::state_t state_nxt;
  logic            accept;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state  = state_r;
  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dda_pkg::ST_IDLE: begin
        if (accept && (in_op == dda_pkg::OP_START)) begin
          state_nxt = dda_pkg::ST_DIV_X;
        end
      end
      dda_pkg::ST_DIV_X: begin
        if (sts.step_zero) begin
          state_nxt = dda_pkg::ST_IDLE;
        end else if (sts.div_last) begin
          state_nxt = dda_pkg::ST_DIV_Y;
        end
      end
      dda_pkg::ST_DIV_Y: begin
        if (sts.div_last) begin
          state_nxt = dda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dda_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    case (state_r)
      dda_pkg::ST_IDLE: begin
        in_stall = sts.out_blocked;
        cmd.load = accept && (in_op == dda_pkg::OP_START);
        cmd.tick = accept && (in_op == dda_pkg::OP_TICK) && sts.pixels_active;
      end
      dda_pkg::ST_DIV_X: begin
        cmd.div_step = !sts.step_zero;
        cmd.commit_x = !sts.step_zero && sts.div_last;
      end
      dda_pkg::ST_DIV_Y: begin
        cmd.div_step = 1'b1;
        cmd.commit_y = sts.div_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/dda_dp.sv */
// datapath for the dda line rasterizer: span logic, shared bit-serial
// divider, position accumulators and output register; depends on dda_pkg
`timescale 1ns / 1ps
`default_nettype none

module dda_dp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dda_pkg::in_beat_t in_data,
  input  wire dda_pkg::cmd_t     cmd,
  output dda_pkg::sts_t          sts,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output dda_pkg::out_beat_t     out_data
);

  localparam int unsigned CB = dda_pkg::COORD_BITS;
  localparam int unsigned PW = CB + FRAC_BITS;      // position width
  localparam int unsigned IW = PW + 1;              // signed increment width
  localparam int unsigned QW = FRAC_BITS + 1;       // quotient width
  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  // span logic on the incoming start beat
  logic [CB-1:0] adx;
  logic [CB-1:0] ady;
  logic [CB-1:0] step_in;
  logic          neg_x_in;
  logic          neg_y_in;

  always_comb begin
    neg_x_in = in_data.x_end < in_data.x_start;
    neg_y_in = in_data.y_end < in_data.y_start;
    adx      = neg_x_in ? (in_data.x_start - in_data.x_end)
                        : (in_data.x_end - in_data.x_start);
    ady      = neg_y_in ? (in_data.y_start - in_data.y_end)
                        : (in_data.y_end - in_data.y_start);
    step_in  = (adx >= ady) ? adx : ady;
  end

  // line registers
  logic [CB-1:0]         step_r;
  logic [CB-1:0]         mag_y_r;
  logic                  neg_x_r;
  logic                  neg_y_r;
  logic [PW-1:0]         pos_x_r;
  logic [PW-1:0]         pos_y_r;
  logic signed [IW-1:0]  inc_x_r;
  logic signed [IW-1:0]  inc_y_r;
  logic [CB:0]           pixels_left_r;

  // divider registers
  logic [CB:0]   rem_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;

  // one restoring step: remainder is always below twice the divisor
  logic          q_bit;
  logic [CB:0]   rem_sub;
  logic [CB:0]   rem_shift;
  logic [QW-1:0] quo_nxt;
  logic [IW-1:0] quo_ext;
  logic [IW-1:0] quo_neg;

  always_comb begin
    q_bit     = rem_r >= {1'b0, step_r};
    rem_sub   = q_bit ? (rem_r - {1'b0, step_r}) : rem_r;
    rem_shift = {rem_sub[CB-1:0], 1'b0};
    quo_nxt   = {quo_r[QW-2:0], q_bit};
    quo_ext   = {{CB{1'b0}}, quo_nxt};
    quo_neg   = (~quo_ext) + {{(IW-1){1'b0}}, 1'b1};
  end

  // divider sequencing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= {1'b0, adx};
      quo_r <= '0;
      cnt_r <= CW'(FRAC_BITS);
    end else if (cmd.commit_x) begin
      rem_r <= {1'b0, mag_y_r};
      quo_r <= '0;
      cnt_r <= CW'(FRAC_BITS);
    end else if (cmd.div_step) begin
      rem_r <= rem_shift;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // line setup and increments
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_r  <= step_in;
      mag_y_r <= ady;
      neg_x_r <= neg_x_in;
      neg_y_r <= neg_y_in;
      inc_x_r <= '0;
      inc_y_r <= '0;
    end else begin
      if (cmd.commit_x) begin
        inc_x_r <= neg_x_r ? quo_neg : quo_ext;
      end
      if (cmd.commit_y) begin
        inc_y_r <= neg_y_r ? quo_neg : quo_ext;
      end
    end
  end

  // position accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r <= {in_data.x_start, {FRAC_BITS{1'b0}}};
      pos_y_r <= {in_data.y_start, {FRAC_BITS{1'b0}}};
    end else if (cmd.tick) begin
      pos_x_r <= pos_x_r + inc_x_r[PW-1:0];
      pos_y_r <= pos_y_r + inc_y_r[PW-1:0];
    end
  end

  // pixel count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
    end else if (cmd.load) begin
      pixels_left_r <= '0;
    end else if (cmd.commit_y) begin
      pixels_left_r <= {1'b0, step_r};
    end else if (cmd.tick) begin
      pixels_left_r <= pixels_left_r - (CB+1)'(1);
    end
  end

  // output register
  logic               out_valid_r;
  dda_pkg::out_beat_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.tick) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      out_data_r.pixel_x    <= pos_x_r[PW-1:FRAC_BITS];
      out_data_r.pixel_y    <= pos_y_r[PW-1:FRAC_BITS];
      out_data_r.last_pixel <= pixels_left_r == (CB+1)'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to controller
  always_comb begin
    sts.step_zero     = step_r == '0;
    sts.div_last      = cnt_r == '0;
    sts.pixels_active = pixels_left_r != '0;
    sts.out_blocked   = out_valid_r && out_stall;
  end

endmodule

`default_nettype wire

/* hw/rtl/dda_line_rasterizer_unit.sv */
// top level of the dda line rasterizer: controller plus datapath
// depends on dda_pkg, dda_ctrl and dda_dp
`timescale 1ns / 1ps
`default_nettype none

// A start beat loads a line and the block then stalls its input while one
// shared restoring divider works out the x and then the y increment, one
// quotient bit per cycle; a zero-length line needs no division. Tick beats are
// then taken one per cycle, each giving one pixel through a single output
// register; the input stalls only while that register is full and stalled.
// A line gives max(|dx|,|dy|) pixels, start point included, end point not,
// with last_pixel set on the final one. Ticks with no line left give nothing.
module dda_line_rasterizer_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dda_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dda_pkg::out_beat_t     out_data
);

  dda_pkg::cmd_t   cmd;
  dda_pkg::sts_t   sts;
  dda_pkg::state_t state;

  // controller
  dda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  // datapath
  dda_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a new line never leaves old pixels armed while dividing
  a_load_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !sts.pixels_active)
    else $error("pixel count still armed after line load");

  // after the y increment the line is armed and the controller is idle
  a_commit_arms: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_y |=> (sts.pixels_active && (state == dda_pkg::ST_IDLE)))
    else $error("line not armed after division");

  // the y division restarts the bit counter
  a_commit_x_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_x |=> (!sts.div_last && (state == dda_pkg::ST_DIV_Y)))
    else $error("divider not restarted for y");

  // no pixel is emitted and no line is loaded while the divider is busy
  a_no_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state != dda_pkg::ST_IDLE) |-> !cmd.tick && !cmd.load)
    else $error("beat taken during division");

endmodule

`default_nettype wire

/* verif/tb_dda_line_rasterizer_unit.sv */
// self-checking testbench for dda_line_rasterizer_unit: random idling on both channels,
// a line-drawing predictor in a small scoreboard class; depends on dda_pkg and the rtl
`timescale 1ns / 1ps

module tb_dda_line_rasterizer_unit;

  localparam int COORD_BITS  = dda_pkg::COORD_BITS;
  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = COORD_BITS + FRAC_BITS;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int BEAT_TARGET = 1450;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 64;
  localparam int IDLE_LIMIT  = 2000;

  // line-drawing predictor and the pixels still owed by the block
  class pixel_scoreboard;
    logic [POS_W-1:0]    x_pos, y_pos;
    longint              x_inc, y_inc;
    logic [COORD_BITS:0] left;
    dda_pkg::out_beat_t  owed_pixels[$];
    int                  err_count;

    function new();
      x_pos = '0;
      y_pos = '0;
      x_inc = 0;
      y_inc = 0;
      left = '0;
      err_count = 0;
    endfunction

    // signed span in fixed point over step, truncated toward zero
    function longint step_increment(int start_c, int end_c, int step);
      longint mag, q;
      mag = (end_c < start_c) ? start_c - end_c : end_c - start_c;
      q = (mag << FRAC_BITS) / step;
      return (end_c < start_c) ? -q : q;
    endfunction

    function int pending_count();
      return owed_pixels.size();
    endfunction

    task report(string what);
      err_count++;
      if (err_count <= 100) $display("mismatch: %s", what);
    endtask

    // accepted input beat: start loads a line, tick may owe a pixel
    function void note_beat(dda_pkg::in_beat_t b);
      int adx, ady, step;
      dda_pkg::out_beat_t px;
      if (b.operation == dda_pkg::OP_START) begin
        adx = (b.x_end >= b.x_start) ? int'(b.x_end) - int'(b.x_start)
                                     : int'(b.x_start) - int'(b.x_end);
        ady = (b.y_end >= b.y_start) ? int'(b.y_end) - int'(b.y_start)
                                     : int'(b.y_start) - int'(b.y_end);
        step = (adx >= ady) ? adx : ady;
        x_pos = POS_W'(b.x_start) << FRAC_BITS;
        y_pos = POS_W'(b.y_start) << FRAC_BITS;
        if (step == 0) begin
          x_inc = 0;
          y_inc = 0;
          left = '0;
        end else begin
          x_inc = step_increment(int'(b.x_start), int'(b.x_end), step);
          y_inc = step_increment(int'(b.y_start), int'(b.y_end), step);
          left = (COORD_BITS + 1)'(step);
        end
      end else if (left != '0) begin
        px.pixel_x = x_pos[POS_W-1 -: COORD_BITS];
        px.pixel_y = y_pos[POS_W-1 -: COORD_BITS];
        px.last_pixel = (left == (COORD_BITS + 1)'(1));
        owed_pixels.push_back(px);
        x_pos = x_pos + POS_W'(x_inc);
        y_pos = y_pos + POS_W'(y_inc);
        left = left - (COORD_BITS + 1)'(1);
      end
    endfunction

    // accepted result beat against the oldest owed pixel
    task check_pixel(dda_pkg::out_beat_t got);
      dda_pkg::out_beat_t want;
      string diffs;
      if (owed_pixels.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) last=%0b with nothing owed",
                         got.pixel_x, got.pixel_y, got.last_pixel));
      end else begin
        want = owed_pixels.pop_front();
        diffs = "";
        if (got.pixel_x !== want.pixel_x)
          diffs = {diffs, $sformatf(" pixel_x %0d/%0d", got.pixel_x, want.pixel_x)};
        if (got.pixel_y !== want.pixel_y)
          diffs = {diffs, $sformatf(" pixel_y %0d/%0d", got.pixel_y, want.pixel_y)};
        if (got.last_pixel !== want.last_pixel)
          diffs = {diffs, $sformatf(" last_pixel %0b/%0b", got.last_pixel, want.last_pixel)};
        if (diffs != "") report({"got/want", diffs});
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  dda_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  dda_pkg::out_beat_t out_data;

  pixel_scoreboard sb = new();
  int  beats_sent = 0;
  int  idle_cycles = 0;
  bit  burst = 1'b0;
  bit  hold_request = 1'b0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dda_line_rasterizer_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // handshake monitors and no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if (out_valid && !out_stall) sb.check_pixel(out_data);
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stall per beat, one long hold on request
  initial begin
    int n;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        n = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        n = burst ? 0 : $urandom_range(0, 12);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic dda_pkg::in_beat_t random_beat();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return dda_pkg::in_beat_t'(raw[$bits(dda_pkg::in_beat_t)-1:0]);
  endfunction

  // endpoint within span_max of c, clipped to the coordinate range
  function automatic int pick_end(int c, int span_max);
    int lo, hi;
    lo = (c > span_max) ? c - span_max : 0;
    hi = (c + span_max < COORD_MAX) ? c + span_max : COORD_MAX;
    return $urandom_range(lo, hi);
  endfunction

  task send_beat(input dda_pkg::in_beat_t b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // start beat followed by a number of tick beats with random payload
  task send_line(input int xs, input int ys, input int xe, input int ye, input int ticks);
    dda_pkg::in_beat_t b;
    b = random_beat();
    b.operation = dda_pkg::OP_START;
    b.x_start = COORD_BITS'(xs);
    b.y_start = COORD_BITS'(ys);
    b.x_end   = COORD_BITS'(xe);
    b.y_end   = COORD_BITS'(ye);
    send_beat(b);
    repeat (ticks) begin
      b = random_beat();
      b.operation = dda_pkg::OP_TICK;
      send_beat(b);
    end
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // stimulus
  initial begin
    int xs, ys, xe, ye, adx, ady, step, ticks, r, span_max;
    dda_pkg::in_beat_t b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // ticks with no line loaded
    repeat (2) begin
      b = random_beat();
      b.operation = dda_pkg::OP_TICK;
      send_beat(b);
    end
    // zero-length line, then a tick that must give nothing
    send_line(500, 500, 500, 500, 1);
    // top corner, both spans negative, one spare tick
    send_line(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 2, 4);
    // y-major from the origin
    send_line(0, 0, 2, 3, 3);
    // diagonal with opposite signs
    send_line(0, COORD_MAX, 3, COORD_MAX - 3, 3);
    // new line replaces one still being drawn
    send_line(COORD_MAX, 0, COORD_MAX - 10, 5, 2);
    send_line(5, 7, 5, 4, 4);

    // back-pressure: receiver holds off while ticks keep coming
    burst = 1'b1;
    hold_request = 1'b1;
    send_line(100, 900, 170, 880, 70);
    burst = 1'b0;
    wait_drained();

    // random lines, mostly short and well formed
    while (beats_sent < BEAT_TARGET) begin
      if ($urandom_range(0, 9) == 0) burst = !burst;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_beat(random_beat());
      end else begin
        span_max = (r < 80) ? 12 : ((r < 97) ? 80 : COORD_MAX);
        xs = $urandom_range(0, COORD_MAX);
        ys = $urandom_range(0, COORD_MAX);
        xe = pick_end(xs, span_max);
        ye = pick_end(ys, span_max);
        adx = (xe >= xs) ? xe - xs : xs - xe;
        ady = (ye >= ys) ? ye - ys : ys - ye;
        step = (adx >= ady) ? adx : ady;
        if ($urandom_range(0, 4) != 0) ticks = step + $urandom_range(0, 2);
        else ticks = $urandom_range(0, step);
        // keep the beat count close to the target
        if (ticks > BEAT_TARGET - beats_sent - 1) ticks = BEAT_TARGET - beats_sent - 1;
        send_line(xs, ys, xe, ye, ticks);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    // drain and let any stray pixel show up
    burst = 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
